### hdl/aes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

	typedef struct packed {
		logic        command;
		logic [63:0] block_high;
		logic [63:0] block_low;
	} aes_in_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} aes_out_t;

	localparam int KeyRegs    = 4;
	localparam int StoreDepth = 60;
	localparam int CfgIdxW    = 3;
	localparam int RkAddrW    = 6;
	localparam int RndW       = 4;

	localparam logic [CfgIdxW-1:0] REG_KEY_LENGTH = 3'd4;
	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_LOAD,
		ST_ROUND,
		ST_DONE
	} aes_state_t;

	// controller to datapath
	typedef struct packed {
		logic              exp_init;
		logic              exp_step;
		logic              load;
		logic              round_step;
		logic              final_round;
		logic [RndW-1:0]   round;
		logic              decrypt;
		logic              done;
	} aes_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic exp_last;
	} aes_sts_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int k = 0; k < 8; k++) begin
			if (b[k]) p = p ^ x;
			x = xtime(x);
		end
		gmul = p;
	endfunction

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

endpackage
`default_nettype wire

### hdl/aes_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module aes_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic            command,
	input  wire logic            cfg_write,
	input  wire logic [1:0]      key_length,
	input  wire aes_pkg::aes_sts_t sts,
	output aes_pkg::aes_cmd_t    cmd,
	output logic                 busy
);
	import aes_pkg::*;

	aes_state_t          state_q, state_next;
	logic                keys_ready_q;
	logic                decrypt_q;
	logic [RndW-1:0]     round_q;
	logic [RndW-1:0]     nr;

	always_comb begin
		unique case (key_length)
			2'd0:    nr = RndW'(10);
			2'd1:    nr = RndW'(12);
			default: nr = RndW'(14);
		endcase
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_next = keys_ready_q ? ST_LOAD : ST_EXPAND;
			end
			ST_EXPAND: begin
				if (sts.exp_last) state_next = ST_LOAD;
			end
			ST_LOAD:  state_next = ST_ROUND;
			ST_ROUND: begin
				if (round_q == nr) state_next = ST_DONE;
			end
			ST_DONE:  state_next = ST_IDLE;
			default:  state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.decrypt = decrypt_q;
		cmd.round = decrypt_q ? nr - round_q : round_q;
		cmd.final_round = (round_q == nr);
		unique case (state_q)
			ST_IDLE:   cmd.exp_init = start && !keys_ready_q;
			ST_EXPAND: cmd.exp_step = 1'b1;
			ST_LOAD:   begin
				cmd.load = 1'b1;
				cmd.round = decrypt_q ? nr : '0;
			end
			ST_ROUND:  cmd.round_step = 1'b1;
			ST_DONE:   cmd.done = 1'b1;
			default:   cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			keys_ready_q <= 1'b0;
			decrypt_q    <= 1'b0;
			round_q      <= '0;
		end else begin
			state_q <= state_next;
			if (cfg_write) keys_ready_q <= 1'b0;
			else if (state_q == ST_EXPAND && sts.exp_last) keys_ready_q <= 1'b1;
			if (state_q == ST_IDLE && start) decrypt_q <= command;
			if (state_q == ST_LOAD) round_q <= RndW'(1);
			else if (state_q == ST_ROUND) round_q <= round_q + RndW'(1);
		end
	end

	property p_expand_keys;
		@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> keys_ready_q;
	endproperty
	assert property (p_expand_keys) else $error("load without expanded keys");

	property p_round_bound;
		@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (round_q <= nr && round_q != '0);
	endproperty
	assert property (p_round_bound) else $error("round counter out of range");

	property p_done_follows;
		@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> (state_q == ST_IDLE);
	endproperty
	assert property (p_done_follows) else $error("done not followed by idle");
endmodule
`default_nettype wire

### hdl/aes_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module aes_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire aes_pkg::aes_cmd_t cmd,
	input  wire aes_pkg::aes_in_t  req,
	input  wire logic              accept,
	input  wire logic [63:0]       key_w0,
	input  wire logic [63:0]       key_w1,
	input  wire logic [63:0]       key_w2,
	input  wire logic [63:0]       key_w3,
	input  wire logic [1:0]        key_length,
	output aes_pkg::aes_sts_t      sts,
	output aes_pkg::aes_out_t      res,
	output logic                   res_valid
);
	import aes_pkg::*;

	// round-key memory: one write port from expansion, one 4-word read
	logic [127:0]        rk_mem [StoreDepth/4];
	logic [RndW-1:0]     rk_rd_row;
	logic [127:0]        rk_row;

	// key expansion: window of the last nk words (up to 8), one word a cycle
	logic [31:0]         win_q [8];
	logic [RkAddrW-1:0]  exp_i_q;
	logic [3:0]          exp_mod_q;
	logic [7:0]          rcon_q;
	logic [127:0]        row_acc_q;
	logic [3:0]          nk;
	logic [RkAddrW-1:0]  total;
	logic [31:0]         t_word;
	logic [31:0]         new_word;
	logic [31:0]         init_words [8];

	logic [127:0]        state_q;
	logic [127:0]        rnd_out;
	logic [127:0]        load_data;
	logic                rk_rd_en;

	always_comb begin
		unique case (key_length)
			2'd0:    nk = 4'd4;
			2'd1:    nk = 4'd6;
			default: nk = 4'd8;
		endcase
		total = RkAddrW'(4 * 11) + RkAddrW'({nk[3:1], 3'b000}) - RkAddrW'(16);
	end

	assign init_words[0] = key_w0[63:32];
	assign init_words[1] = key_w0[31:0];
	assign init_words[2] = key_w1[63:32];
	assign init_words[3] = key_w1[31:0];
	assign init_words[4] = key_w2[63:32];
	assign init_words[5] = key_w2[31:0];
	assign init_words[6] = key_w3[63:32];
	assign init_words[7] = key_w3[31:0];

	// win_q[k] holds word i-nk+k for k < nk; word i-1 sits at nk-1
	always_comb begin
		t_word = win_q[nk[2:0] - 3'd1];
		if (exp_i_q < RkAddrW'(nk)) begin
			new_word = init_words[exp_i_q[2:0]];
		end else begin
			if (exp_mod_q == 4'd0)
				t_word = sub_word({t_word[23:0], t_word[31:24]}) ^ {rcon_q, 24'h0};
			else if (nk == 4'd8 && exp_mod_q == 4'd4)
				t_word = sub_word(t_word);
			new_word = win_q[0] ^ t_word;
		end
	end

	assign sts.exp_last = (exp_i_q == total - RkAddrW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_i_q   <= '0;
			exp_mod_q <= '0;
			rcon_q    <= 8'h01;
		end else if (cmd.exp_init) begin
			exp_i_q   <= '0;
			exp_mod_q <= '0;
			rcon_q    <= 8'h01;
		end else if (cmd.exp_step) begin
			exp_i_q   <= exp_i_q + RkAddrW'(1);
			exp_mod_q <= (exp_mod_q == nk - 4'd1) ? 4'd0 : exp_mod_q + 4'd1;
			if (exp_i_q >= RkAddrW'(nk) && exp_mod_q == 4'd0) rcon_q <= xtime(rcon_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exp_step) begin
			if (exp_i_q < RkAddrW'(nk)) begin
				win_q[exp_i_q[2:0]] <= new_word;
			end else begin
				for (int k = 0; k < 7; k++)
					win_q[k] <= (3'(k) == nk[2:0] - 3'd1) ? new_word : win_q[k + 1];
				if (nk == 4'd8) win_q[7] <= new_word;
			end
			row_acc_q <= {row_acc_q[95:0], new_word};
			if (exp_i_q[1:0] == 2'd3)
				rk_mem[exp_i_q[RkAddrW-1:2]] <= {row_acc_q[95:0], new_word};
		end
	end

	// register next round's key row ahead of its use
	assign rk_rd_en = cmd.exp_init || cmd.exp_step || accept || cmd.load ||
		(cmd.round_step && !cmd.final_round);
	always_comb begin
		if (accept)
			rk_rd_row = req.command ? RndW'(4'd10) + RndW'({key_length == 2'd0 ? 2'd0 :
				(key_length == 2'd1 ? 2'd1 : 2'd2), 1'b0}) : '0;
		else if (cmd.load)
			rk_rd_row = cmd.decrypt ? cmd.round - RndW'(1) : RndW'(1);
		else if (cmd.decrypt)
			rk_rd_row = cmd.round - RndW'(1);
		else
			rk_rd_row = cmd.round + RndW'(1);
	end

	always_ff @(posedge clk) begin
		if (rk_rd_en && !cmd.exp_step) rk_row <= rk_mem[rk_rd_row];
		else if (cmd.exp_step && sts.exp_last)
			rk_row <= cmd.decrypt ? {row_acc_q[95:0], new_word} : rk_mem[0];
	end

	// one round per cycle
	always_comb begin
		logic [7:0] s   [16];
		logic [7:0] t   [16];
		logic [7:0] m   [16];
		for (int k = 0; k < 16; k++) s[k] = state_q[127 - 8*k -: 8];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[r + 4*c] = cmd.decrypt ? INV_SBOX[s[r + 4*((c - r + 4) & 3)]]
					: SBOX[s[r + 4*((c + r) & 3)]];
		if (!cmd.decrypt) begin
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					m[r + 4*c] = cmd.final_round ? t[r + 4*c] :
						gmul(8'd2, t[r + 4*c]) ^ gmul(8'd3, t[((r+1)&3) + 4*c]) ^
						t[((r+2)&3) + 4*c] ^ t[((r+3)&3) + 4*c];
			for (int k = 0; k < 16; k++) m[k] = m[k] ^ rk_row[127 - 8*k -: 8];
		end else begin
			for (int k = 0; k < 16; k++) t[k] = t[k] ^ rk_row[127 - 8*k -: 8];
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					m[r + 4*c] = cmd.final_round ? t[r + 4*c] :
						gmul(8'd14, t[r + 4*c]) ^ gmul(8'd11, t[((r+1)&3) + 4*c]) ^
						gmul(8'd13, t[((r+2)&3) + 4*c]) ^ gmul(8'd9, t[((r+3)&3) + 4*c]);
		end
		for (int k = 0; k < 16; k++) rnd_out[127 - 8*k -: 8] = m[k];
	end

	always_ff @(posedge clk) begin
		if (accept) load_data <= {req.block_high, req.block_low};
		if (cmd.load) state_q <= load_data ^ rk_row;
		else if (cmd.round_step) state_q <= rnd_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid <= 1'b0;
		else res_valid <= cmd.done;
	end
	assign res = '{result_high: state_q[127:64], result_low: state_q[63:0]};
endmodule
`default_nettype wire

### hdl/aes_block_cipher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake                 payload
// request   in         start & !busy             req (command, block_high, block_low)
// result    out        done strobe, one cycle    res (result_high, result_low)
// config    in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// A block runs a load, Nr rounds (10, 12 or 14) and a done step; the single shared
// round unit runs one round a cycle. After a configuration write the next request
// first expands the key into 44, 52 or 60 round-key words, one word a cycle.
// Reset clears control state; round keys are rebuilt before first use.
// The receiver cannot stall; done is registered from ST_DONE, after the last round.
module aes_block_cipher_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire aes_pkg::aes_in_t               req,
	output logic                                done,
	output aes_pkg::aes_out_t                   res,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [aes_pkg::CfgIdxW-1:0]    cfg_index,
	input  wire logic [63:0]                    cfg_data
);
	import aes_pkg::*;

	logic [63:0]  key_q [KeyRegs];
	logic [1:0]   key_length_q;
	logic [1:0]   nk_sel;
	logic         cfg_write;
	logic         accept;
	aes_cmd_t     cmd;
	aes_sts_t     sts;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready &&
		(cfg_index < CfgIdxW'(KeyRegs) || cfg_index == REG_KEY_LENGTH);
	assign accept = start && !busy;
	assign nk_sel = (key_length_q == 2'd3) ? 2'd2 : key_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KeyRegs; k++) key_q[k] <= '0;
			key_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_KEY_LENGTH) key_length_q <= cfg_data[1:0];
			else if (cfg_index < CfgIdxW'(KeyRegs)) key_q[cfg_index[1:0]] <= cfg_data;
		end
	end

	aes_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.command    (req.command),
		.cfg_write  (cfg_write),
		.key_length (nk_sel),
		.sts        (sts),
		.cmd        (cmd),
		.busy       (busy)
	);

	aes_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.req        (req),
		.accept     (accept),
		.key_w0     (key_q[0]),
		.key_w1     (key_q[1]),
		.key_w2     (key_q[2]),
		.key_w3     (key_q[3]),
		.key_length (nk_sel),
		.sts        (sts),
		.res        (res),
		.res_valid  (done)
	);

	property p_no_accept_busy;
		@(posedge clk) disable iff (!arst_n)
		accept |=> busy;
	endproperty
	assert property (p_no_accept_busy) else $error("request accepted without busy");

	property p_done_idle;
		@(posedge clk) disable iff (!arst_n)
		done |-> !busy;
	endproperty
	assert property (p_done_idle) else $error("result while busy");

	property p_cfg_idle;
		@(posedge clk) disable iff (!arst_n)
		cfg_write |-> !busy;
	endproperty
	assert property (p_cfg_idle) else $error("configuration write while busy");
endmodule
`default_nettype wire
